[rtl/core/lrfbs_pkg.sv]
// shared types and constants for the lcd rectangle fill bus sequencer
`timescale 1ns / 1ps
`default_nettype none

package lrfbs_pkg;

    // default screen size in pixels
    localparam int DEFAULT_SCREEN_WIDTH  = 240;
    localparam int DEFAULT_SCREEN_HEIGHT = 320;

    // field widths
    localparam int COORD_W = 16;
    localparam int COLOR_W = 16;
    localparam int BYTE_W  = 8;

    // command bytes
    localparam logic [BYTE_W-1:0] MEMORY_WRITE_CMD     = 8'h2C;
    localparam logic [BYTE_W-1:0] RESET_COLUMN_SET_CMD = 8'd42;
    localparam logic [BYTE_W-1:0] RESET_PAGE_SET_CMD   = 8'd43;

    // configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_SET_CMD = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_PAGE_SET_CMD   = 1'b1;

    // input item kinds
    localparam logic MODE_REQUEST = 1'b0;
    localparam logic MODE_TICK    = 1'b1;

    // one input item
    typedef struct packed {
        logic                      mode;
        logic signed [COORD_W-1:0] rect_x;
        logic signed [COORD_W-1:0] rect_y;
        logic signed [COORD_W-1:0] rect_w;
        logic signed [COORD_W-1:0] rect_h;
        logic [COLOR_W-1:0]        fill_color;
    } req_t;

    // one result item
    typedef struct packed {
        logic              accepted;
        logic              byte_valid;
        logic [BYTE_W-1:0] bus_byte;
        logic              is_command;
        logic              last_byte;
    } res_t;

endpackage

`default_nettype wire

[rtl/core/lrfbs_clip.sv]
// clips one signed span [start, start+len-1] to [0, LIMIT-1]
`timescale 1ns / 1ps
`default_nettype none

module lrfbs_clip #(
    parameter int LIMIT = lrfbs_pkg::DEFAULT_SCREEN_WIDTH,
    localparam int CW   = (LIMIT > 1) ? $clog2(LIMIT) : 1
) (
    input  wire logic signed [lrfbs_pkg::COORD_W-1:0] start,
    input  wire logic signed [lrfbs_pkg::COORD_W-1:0] len,
    output logic                                      ok,
    output logic [CW-1:0]                             lo,
    output logic [CW-1:0]                             hi
);

    localparam int EW = lrfbs_pkg::COORD_W + 2;
    localparam logic signed [EW-1:0] LIMIT_E = EW'(LIMIT);

    logic signed [EW-1:0] start_e;
    logic signed [EW-1:0] len_e;
    logic signed [EW-1:0] end_e;

    // far edge computed wide so it never wraps
    assign start_e = EW'(start);
    assign len_e   = EW'(len);
    assign end_e   = start_e + len_e - EW'(1);

    // empty when no length, past the far limit or wholly before zero
    assign ok = (len_e > EW'(0)) && (start_e < LIMIT_E) && (end_e >= EW'(0));

    // clamp both ends into the screen
    assign lo = (start_e < EW'(0)) ? '0 : start_e[CW-1:0];
    assign hi = (end_e >= LIMIT_E) ? CW'(LIMIT - 1) : end_e[CW-1:0];

endmodule

`default_nettype wire

[rtl/core/lrfbs_engine.sv]
// fill state, bus byte sequencer and result register
`timescale 1ns / 1ps
`default_nettype none

module lrfbs_engine #(
    parameter int SCREEN_WIDTH  = lrfbs_pkg::DEFAULT_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = lrfbs_pkg::DEFAULT_SCREEN_HEIGHT,
    localparam int XW = (SCREEN_WIDTH > 1) ? $clog2(SCREEN_WIDTH) : 1,
    localparam int YW = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    input  wire lrfbs_pkg::req_t                in_req,
    input  wire logic                           x_ok,
    input  wire logic [XW-1:0]                  x_lo,
    input  wire logic [XW-1:0]                  x_hi,
    input  wire logic                           y_ok,
    input  wire logic [YW-1:0]                  y_lo,
    input  wire logic [YW-1:0]                  y_hi,
    input  wire logic [lrfbs_pkg::BYTE_W-1:0]   column_cmd,
    input  wire logic [lrfbs_pkg::BYTE_W-1:0]   page_cmd,
    output logic                                take,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output lrfbs_pkg::res_t                     out_res
);

    localparam int PW     = $clog2(SCREEN_WIDTH * SCREEN_HEIGHT + 1);
    localparam int PROD_W = XW + YW + 2;
    localparam int BW     = lrfbs_pkg::BYTE_W;

    // sequence steps
    localparam logic [3:0] STEP_COL_CMD  = 4'd0;
    localparam logic [3:0] STEP_XS_HI    = 4'd1;
    localparam logic [3:0] STEP_XS_LO    = 4'd2;
    localparam logic [3:0] STEP_XE_HI    = 4'd3;
    localparam logic [3:0] STEP_XE_LO    = 4'd4;
    localparam logic [3:0] STEP_PAGE_CMD = 4'd5;
    localparam logic [3:0] STEP_YS_HI    = 4'd6;
    localparam logic [3:0] STEP_YS_LO    = 4'd7;
    localparam logic [3:0] STEP_YE_HI    = 4'd8;
    localparam logic [3:0] STEP_YE_LO    = 4'd9;
    localparam logic [3:0] STEP_MEM_CMD  = 4'd10;
    localparam logic [3:0] STEP_PIXELS   = 4'd11;

    logic                               busy_reg, busy_next;
    logic [3:0]                         step_reg, step_next;
    logic [XW-1:0]                      xs_reg, xs_next;
    logic [XW-1:0]                      xe_reg, xe_next;
    logic [YW-1:0]                      ys_reg, ys_next;
    logic [YW-1:0]                      ye_reg, ye_next;
    logic [lrfbs_pkg::COLOR_W-1:0]      color_reg, color_next;
    logic [PW-1:0]                      pixels_left_reg, pixels_left_next;
    logic                               low_reg, low_next;
    logic                               out_valid_reg, out_valid_next;
    lrfbs_pkg::res_t                    res_reg, res_next;

    logic [XW:0]                        span_x;
    logic [YW:0]                        span_y;
    logic [PROD_W-1:0]                  area;
    logic [15:0]                        xs_w, xe_w, ys_w, ye_w;

    // an item moves on when the result register is free or being drained
    assign take      = in_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

    // clipped area of a new request
    assign span_x = {1'b0, x_hi} - {1'b0, x_lo} + (XW + 1)'(1);
    assign span_y = {1'b0, y_hi} - {1'b0, y_lo} + (YW + 1)'(1);
    assign area   = PROD_W'(span_x) * PROD_W'(span_y);

    // window edges widened for byte selection
    assign xs_w = 16'(xs_reg);
    assign xe_w = 16'(xe_reg);
    assign ys_w = 16'(ys_reg);
    assign ye_w = 16'(ye_reg);

    // request handling and byte sequencing
    always_comb
    begin
        busy_next        = busy_reg;
        step_next        = step_reg;
        xs_next          = xs_reg;
        xe_next          = xe_reg;
        ys_next          = ys_reg;
        ye_next          = ye_reg;
        color_next       = color_reg;
        pixels_left_next = pixels_left_reg;
        low_next         = low_reg;
        res_next         = '0;
        if (take)
        begin
            if (in_req.mode == lrfbs_pkg::MODE_REQUEST)
            begin
                if (!busy_reg && x_ok && y_ok)
                begin
                    xs_next           = x_lo;
                    xe_next           = x_hi;
                    ys_next           = y_lo;
                    ye_next           = y_hi;
                    color_next        = in_req.fill_color;
                    pixels_left_next  = area[PW-1:0];
                    low_next          = 1'b0;
                    step_next         = STEP_COL_CMD;
                    busy_next         = 1'b1;
                    res_next.accepted = 1'b1;
                end
            end
            else if (busy_reg)
            begin
                res_next.byte_valid = 1'b1;
                case (step_reg)
                    STEP_COL_CMD:
                    begin
                        res_next.bus_byte   = column_cmd;
                        res_next.is_command = 1'b1;
                    end
                    STEP_XS_HI:    res_next.bus_byte = xs_w[15:8];
                    STEP_XS_LO:    res_next.bus_byte = xs_w[7:0];
                    STEP_XE_HI:    res_next.bus_byte = xe_w[15:8];
                    STEP_XE_LO:    res_next.bus_byte = xe_w[7:0];
                    STEP_PAGE_CMD:
                    begin
                        res_next.bus_byte   = page_cmd;
                        res_next.is_command = 1'b1;
                    end
                    STEP_YS_HI:    res_next.bus_byte = ys_w[15:8];
                    STEP_YS_LO:    res_next.bus_byte = ys_w[7:0];
                    STEP_YE_HI:    res_next.bus_byte = ye_w[15:8];
                    STEP_YE_LO:    res_next.bus_byte = ye_w[7:0];
                    STEP_MEM_CMD:
                    begin
                        res_next.bus_byte   = lrfbs_pkg::MEMORY_WRITE_CMD;
                        res_next.is_command = 1'b1;
                    end
                    default:
                    begin
                        // color bytes, high then low, once per pixel
                        if (low_reg)
                        begin
                            res_next.bus_byte = color_reg[BW-1:0];
                            low_next          = 1'b0;
                            if (pixels_left_reg != '0)
                            begin
                                pixels_left_next = pixels_left_reg - PW'(1);
                            end
                            if (pixels_left_next == '0)
                            begin
                                res_next.last_byte = 1'b1;
                                busy_next          = 1'b0;
                                step_next          = STEP_COL_CMD;
                            end
                        end
                        else
                        begin
                            res_next.bus_byte = color_reg[2*BW-1:BW];
                            low_next          = 1'b1;
                        end
                    end
                endcase
                if (step_reg < STEP_PIXELS)
                begin
                    step_next = step_reg + 4'd1;
                end
            end
        end
    end

    // result register handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg        <= 1'b0;
            step_reg        <= STEP_COL_CMD;
            pixels_left_reg <= '0;
            low_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            busy_reg        <= busy_next;
            step_reg        <= step_next;
            pixels_left_reg <= pixels_left_next;
            low_reg         <= low_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // window, color and result payload
    always_ff @(posedge clk)
    begin
        xs_reg    <= xs_next;
        xe_reg    <= xe_next;
        ys_reg    <= ys_next;
        ye_reg    <= ye_next;
        color_reg <= color_next;
        if (take)
        begin
            res_reg <= res_next;
        end
    end

`ifndef SYNTHESIS
    // an idle engine always restarts at the column command
    a_idle_step: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> step_reg == STEP_COL_CMD)
        else $error("idle engine with nonzero sequence step");

    // low color byte pending only inside the pixel phase
    a_low_in_pixels: assert property (@(posedge clk) disable iff (!rst_n)
        low_reg |-> (busy_reg && step_reg == STEP_PIXELS))
        else $error("low byte pending outside pixel phase");

    // a running fill always has pixels to send
    a_busy_pixels: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> pixels_left_reg != '0)
        else $error("busy with no pixels left");

    // a delivered last byte ends the fill
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (take && res_next.last_byte) |=> (!busy_reg && out_res.last_byte))
        else $error("last byte did not end the fill");

    // a result never both accepts a request and carries a byte
    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(res_reg.accepted && res_reg.byte_valid))
        else $error("result flagged as both request and byte");
`endif

endmodule

`default_nettype wire

[rtl/core/lcd_rect_fill_bus_sequencer.sv]
// top level of the lcd rectangle fill bus sequencer
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  tuser: mode; tdata: rect x,y,w,h, fill color
//  m_*       out  m_tvalid/m_tready  tuser: is_command; tlast: last_byte;
//                                    tdata: accepted, byte_valid, bus_byte
//  cfg_*     in   cfg_valid/cfg_ready index 0 column-set cmd, 1 page-set cmd
//
// one item per cycle sustained while m_tready stays high; each item passes from input
// transfer to result through the input register and the result register.
// the clip, area multiply and byte select sit between those two registers.
// rst_n clears control state and restores the command bytes to 0x2A / 0x2B.
// a stalled output holds its result while the input register still takes
// one more item; the configuration port is always ready.
`timescale 1ns / 1ps
`default_nettype none

module lcd_rect_fill_bus_sequencer #(
    parameter int SCREEN_WIDTH  = lrfbs_pkg::DEFAULT_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = lrfbs_pkg::DEFAULT_SCREEN_HEIGHT,
    localparam int XW = (SCREEN_WIDTH > 1) ? $clog2(SCREEN_WIDTH) : 1,
    localparam int YW = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // input items
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [79:0]                         s_tdata,  // rect_x, rect_y, rect_w, rect_h, fill_color
    input  wire logic                                s_tuser,  // mode
    // result items
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [15:0]                              m_tdata,  // accepted, byte_valid, bus_byte, zero fill
    output logic                                     m_tuser,  // is_command
    output logic                                     m_tlast,  // last_byte
    // configuration writes
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [lrfbs_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [lrfbs_pkg::BYTE_W-1:0]        cfg_data
);

    localparam int CW = lrfbs_pkg::COORD_W;

    logic                              in_valid_reg, in_valid_next;
    lrfbs_pkg::req_t                   in_req_reg;
    lrfbs_pkg::req_t                   s_req;
    logic [lrfbs_pkg::BYTE_W-1:0]      column_cmd_reg, column_cmd_next;
    logic [lrfbs_pkg::BYTE_W-1:0]      page_cmd_reg, page_cmd_next;
    logic                              take;
    logic                              x_ok, y_ok;
    logic [XW-1:0]                     x_lo, x_hi;
    logic [YW-1:0]                     y_lo, y_hi;
    lrfbs_pkg::res_t                   res;

    // unpack the input transfer
    assign s_req.mode       = s_tuser;
    assign s_req.rect_x     = s_tdata[CW-1:0];
    assign s_req.rect_y     = s_tdata[2*CW-1:CW];
    assign s_req.rect_w     = s_tdata[3*CW-1:2*CW];
    assign s_req.rect_h     = s_tdata[4*CW-1:3*CW];
    assign s_req.fill_color = s_tdata[79:4*CW];

    // input register
    assign s_tready = !in_valid_reg || take;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (take)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_req_reg <= s_req;
        end
    end

    // configuration registers
    assign cfg_ready = 1'b1;

    always_comb
    begin
        column_cmd_next = column_cmd_reg;
        page_cmd_next   = page_cmd_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                lrfbs_pkg::REG_COLUMN_SET_CMD: column_cmd_next = cfg_data;
                lrfbs_pkg::REG_PAGE_SET_CMD:   page_cmd_next   = cfg_data;
                default:
                begin
                    column_cmd_next = column_cmd_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_cmd_reg <= lrfbs_pkg::RESET_COLUMN_SET_CMD;
            page_cmd_reg   <= lrfbs_pkg::RESET_PAGE_SET_CMD;
        end
        else
        begin
            column_cmd_reg <= column_cmd_next;
            page_cmd_reg   <= page_cmd_next;
        end
    end

    // clip both axes of the registered request
    lrfbs_clip #(
        .LIMIT (SCREEN_WIDTH)
    ) u_clip_x (
        .start (in_req_reg.rect_x),
        .len   (in_req_reg.rect_w),
        .ok    (x_ok),
        .lo    (x_lo),
        .hi    (x_hi)
    );

    lrfbs_clip #(
        .LIMIT (SCREEN_HEIGHT)
    ) u_clip_y (
        .start (in_req_reg.rect_y),
        .len   (in_req_reg.rect_h),
        .ok    (y_ok),
        .lo    (y_lo),
        .hi    (y_hi)
    );

    // fill state and result register
    lrfbs_engine #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid_reg),
        .in_req     (in_req_reg),
        .x_ok       (x_ok),
        .x_lo       (x_lo),
        .x_hi       (x_hi),
        .y_ok       (y_ok),
        .y_lo       (y_lo),
        .y_hi       (y_hi),
        .column_cmd (column_cmd_reg),
        .page_cmd   (page_cmd_reg),
        .take       (take),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_res    (res)
    );

    // pack the result transfer
    assign m_tdata = {6'b0, res.bus_byte, res.byte_valid, res.accepted};
    assign m_tuser = res.is_command;
    assign m_tlast = res.last_byte;

endmodule

`default_nettype wire

[verif/tb_lcd_rect_fill_bus_sequencer.sv]
// self-checking testbench for the lcd rectangle fill bus sequencer
`timescale 1ns / 1ps

module tb_lcd_rect_fill_bus_sequencer;

    import lrfbs_pkg::*;

    localparam int SCR_W          = DEFAULT_SCREEN_WIDTH;
    localparam int SCR_H          = DEFAULT_SCREEN_HEIGHT;
    localparam int PIXEL_STEP     = 11;
    localparam int RANDOM_ITEMS   = 1395;
    localparam int MAX_RAND_AREA  = 256;
    localparam int LONG_HOLD      = 150;
    localparam int WATCHDOG_LIMIT = 4000;

    // directed stimulus row
    typedef struct {
        req_t item;
        bit   typed;
        res_t want;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [BYTE_W-1:0]      cfg_data;

    // sequencer copy: command registers
    logic [7:0]  col_cmd  = RESET_COLUMN_SET_CMD;
    logic [7:0]  page_cmd = RESET_PAGE_SET_CMD;
    // sequencer copy: fill engine state
    bit          eng_busy;
    int          seq_pos;
    logic [15:0] win_x0, win_x1, win_y0, win_y1;
    logic [15:0] fill_q;
    int          px_left;
    bit          color_lo_next;

    res_t        expected_bus_q[$];
    dir_row_t    dir_rows[$];
    res_t        got_r, want_r;
    int          mismatches;
    int          items_sent;
    int          idle_cycles;
    int          hold_cnt;
    bit          hold_req;
    bit          no_gaps;
    int          episode;

    lcd_rect_fill_bus_sequencer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // clip one axis to [0, limit-1], edges in 32 bits so nothing wraps
    function automatic bit clip_span_to(input int start, input int len, input int limit,
                                        output int lo, output int hi);
        int end_pos;
        lo = 0;
        hi = 0;
        if (len <= 0 || start >= limit)
            return 1'b0;
        end_pos = start + len - 1;
        if (end_pos < 0)
            return 1'b0;
        lo = (start < 0) ? 0 : start;
        hi = (end_pos >= limit) ? limit - 1 : end_pos;
        return 1'b1;
    endfunction

    // clipped pixel count of a request, zero when nothing is left
    function automatic int clipped_area(req_t it);
        int xs, xe, ys, ye;
        if (clip_span_to($signed(it.rect_x), $signed(it.rect_w), SCR_W, xs, xe) &&
            clip_span_to($signed(it.rect_y), $signed(it.rect_h), SCR_H, ys, ye))
            return (xe - xs + 1) * (ye - ys + 1);
        return 0;
    endfunction

    // next bus result for one input item, advancing the engine copy
    function automatic res_t predict_bus_byte(req_t it);
        res_t r;
        int xs, xe, ys, ye;
        r = '0;
        if (it.mode == MODE_REQUEST)
        begin
            if (!eng_busy &&
                clip_span_to($signed(it.rect_x), $signed(it.rect_w), SCR_W, xs, xe) &&
                clip_span_to($signed(it.rect_y), $signed(it.rect_h), SCR_H, ys, ye))
            begin
                win_x0        = 16'(xs);
                win_x1        = 16'(xe);
                win_y0        = 16'(ys);
                win_y1        = 16'(ye);
                fill_q        = it.fill_color;
                px_left       = (xe - xs + 1) * (ye - ys + 1);
                color_lo_next = 1'b0;
                seq_pos       = 0;
                eng_busy      = 1'b1;
                r.accepted    = 1'b1;
            end
        end
        else if (eng_busy)
        begin
            r.byte_valid = 1'b1;
            case (seq_pos)
                // column window
                0:  begin r.bus_byte = col_cmd; r.is_command = 1'b1; end
                1:  r.bus_byte = win_x0[15:8];
                2:  r.bus_byte = win_x0[7:0];
                3:  r.bus_byte = win_x1[15:8];
                4:  r.bus_byte = win_x1[7:0];
                // page window
                5:  begin r.bus_byte = page_cmd; r.is_command = 1'b1; end
                6:  r.bus_byte = win_y0[15:8];
                7:  r.bus_byte = win_y0[7:0];
                8:  r.bus_byte = win_y1[15:8];
                9:  r.bus_byte = win_y1[7:0];
                10: begin r.bus_byte = MEMORY_WRITE_CMD; r.is_command = 1'b1; end
                // color bytes, high first
                default:
                begin
                    if (color_lo_next)
                    begin
                        r.bus_byte    = fill_q[7:0];
                        color_lo_next = 1'b0;
                        if (px_left > 0)
                            px_left--;
                        if (px_left == 0)
                        begin
                            r.last_byte = 1'b1;
                            eng_busy    = 1'b0;
                            seq_pos     = 0;
                        end
                    end
                    else
                    begin
                        r.bus_byte    = fill_q[15:8];
                        color_lo_next = 1'b1;
                    end
                end
            endcase
            if (seq_pos < PIXEL_STEP && eng_busy)
                seq_pos++;
        end
        return r;
    endfunction

    // gap before the next transfer, mostly short
    function automatic int next_gap();
        int p;
        if (no_gaps)
            return 0;
        p = $urandom_range(0, 99);
        if (p < 60)
            return 0;
        if (p < 88)
            return $urandom_range(1, 3);
        if (p < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 45);
    endfunction

    // any item with every field random
    function automatic req_t noise_item(logic mode);
        req_t it;
        it      = req_t'({$urandom, $urandom, $urandom});
        it.mode = mode;
        return it;
    endfunction

    // random request that either survives clipping with a bounded area or is rejected
    function automatic req_t fill_request(bit want_draw);
        req_t it;
        int   style, area, tries;
        for (tries = 0; tries < 500; tries++)
        begin
            it    = noise_item(MODE_REQUEST);
            style = $urandom_range(0, 9);
            if (want_draw)
            begin
                if (style < 6)
                begin
                    it.rect_x = 16'(int'($urandom_range(0, 247)) - 4);
                    it.rect_y = 16'(int'($urandom_range(0, 327)) - 4);
                    it.rect_w = 16'($urandom_range(1, 6));
                    it.rect_h = 16'($urandom_range(1, 6));
                end
                else if (style < 8)
                begin
                    // horizontal or vertical line
                    it.rect_x = 16'(int'($urandom_range(0, 259)) - 10);
                    it.rect_y = 16'(int'($urandom_range(0, 339)) - 10);
                    it.rect_w = 16'($urandom_range(1, 60));
                    it.rect_h = 16'd1;
                    if (style == 7)
                    begin
                        it.rect_h = it.rect_w;
                        it.rect_w = 16'd1;
                    end
                end
                else if (style < 9)
                begin
                    it.rect_x = 16'($urandom_range(0, 239));
                    it.rect_y = 16'($urandom_range(0, 319));
                    it.rect_w = 16'($urandom_range(1, 20));
                    it.rect_h = 16'($urandom_range(1, 12));
                end
                else
                begin
                    // full-range column span, thin rows
                    it.rect_y = 16'(int'($urandom_range(0, 323)) - 2);
                    it.rect_h = 16'($urandom_range(1, 2));
                end
                area = clipped_area(it);
                if (area > 0 && area <= MAX_RAND_AREA)
                    return it;
            end
            else
            begin
                if (style < 3)
                    it.rect_w = 16'(0 - $urandom_range(0, 32768));
                else if (style < 4)
                    it.rect_h = 16'(0 - $urandom_range(0, 32768));
                else if (style < 5)
                    it.rect_x = 16'($urandom_range(SCR_W, 32767));
                else if (style < 6)
                    it.rect_y = 16'($urandom_range(SCR_H, 32767));
                else if (style < 8)
                begin
                    // span ends left of the screen
                    it.rect_x = 16'(0 - $urandom_range(1, 32768));
                    it.rect_w = 16'($urandom_range(1, 32767) % (-$signed(it.rect_x)));
                end
                if (clipped_area(it) == 0)
                    return it;
            end
        end
        it        = noise_item(MODE_REQUEST);
        it.rect_x = 16'd0;
        it.rect_y = 16'd0;
        it.rect_w = want_draw ? 16'd1 : 16'd0;
        it.rect_h = 16'd1;
        return it;
    endfunction

    function automatic dir_row_t mk_row(logic mode, int x, int y, int w, int h, int color,
                                        bit typed, res_t want);
        dir_row_t row;
        row.item.mode       = mode;
        row.item.rect_x     = 16'(x);
        row.item.rect_y     = 16'(y);
        row.item.rect_w     = 16'(w);
        row.item.rect_h     = 16'(h);
        row.item.fill_color = 16'(color);
        row.typed           = typed;
        row.want            = want;
        return row;
    endfunction

    function automatic res_t bus_res(logic [7:0] b, logic cmd, logic fin);
        res_t r;
        r            = '0;
        r.byte_valid = 1'b1;
        r.bus_byte   = b;
        r.is_command = cmd;
        r.last_byte  = fin;
        return r;
    endfunction

    // one input transfer; the expected result is queued at acceptance
    task automatic send_item(req_t it, bit typed = 1'b0, res_t want = '0);
        int   gap;
        res_t pred;
        gap = next_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= it.mode;
        s_tdata  <= {it.fill_color, it.rect_h, it.rect_w, it.rect_y, it.rect_x};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pred = predict_bus_byte(it);
        expected_bus_q.push_back(typed ? want : pred);
        items_sent++;
    endtask

    // stop offering and wait for every expected result
    task automatic wait_quiet();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_bus_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [7:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_COLUMN_SET_CMD)
            col_cmd = val;
        else
            page_cmd = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // tick out the running fill, with ignored requests mixed in
    task automatic drain_fill();
        while (eng_busy)
        begin
            if ($urandom_range(0, 99) < 8)
                send_item(noise_item(MODE_REQUEST));
            else
                send_item(noise_item(MODE_TICK));
        end
    endtask

    // receiver: random stalls plus one long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        hold_cnt = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_cnt = LONG_HOLD;
                hold_req = 1'b0;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!no_gaps && $urandom_range(0, 99) < 30)
                    hold_cnt = next_gap();
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_r.accepted   = m_tdata[0];
            got_r.byte_valid = m_tdata[1];
            got_r.bus_byte   = m_tdata[9:2];
            got_r.is_command = m_tuser;
            got_r.last_byte  = m_tlast;
            if (expected_bus_q.size() == 0)
            begin
                $error("result transfer with nothing expected");
                mismatches++;
            end
            else
            begin
                want_r = expected_bus_q.pop_front();
                if (got_r.accepted !== want_r.accepted)
                begin
                    $error("accepted: expected %0d, got %0d", want_r.accepted, got_r.accepted);
                    mismatches++;
                end
                if (got_r.byte_valid !== want_r.byte_valid)
                begin
                    $error("byte_valid: expected %0d, got %0d",
                           want_r.byte_valid, got_r.byte_valid);
                    mismatches++;
                end
                if (got_r.bus_byte !== want_r.bus_byte)
                begin
                    $error("bus_byte: expected %02h, got %02h", want_r.bus_byte, got_r.bus_byte);
                    mismatches++;
                end
                if (got_r.is_command !== want_r.is_command)
                begin
                    $error("is_command: expected %0d, got %0d",
                           want_r.is_command, got_r.is_command);
                    mismatches++;
                end
                if (got_r.last_byte !== want_r.last_byte)
                begin
                    $error("last_byte: expected %0d, got %0d", want_r.last_byte, got_r.last_byte);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles with no transfer anywhere
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // main stimulus
    initial
    begin
        res_t acc_r;
        res_t idle_r;
        req_t big;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = MODE_TICK;
        cfg_valid   = 1'b0;
        cfg_index   = REG_COLUMN_SET_CMD;
        cfg_data    = '0;
        mismatches  = 0;
        items_sent  = 0;
        idle_cycles = 0;
        hold_req    = 1'b0;
        no_gaps     = 1'b0;
        episode     = 0;
        acc_r          = '0;
        acc_r.accepted = 1'b1;
        idle_r         = '0;

        // directed rows: idle tick, a one-pixel fill at reset commands, rejects
        dir_rows.push_back(mk_row(MODE_TICK,    0, 0, 0, 0, 16'hFFFF, 1, idle_r));
        dir_rows.push_back(mk_row(MODE_REQUEST, 0, 0, 1, 1, 16'hA5C3, 1, acc_r));
        dir_rows.push_back(mk_row(MODE_REQUEST, 0, 0, 5, 5, 16'h1234, 1, idle_r));
        dir_rows.push_back(mk_row(MODE_TICK, 0, 0, 0, 0, 0, 1, bus_res(8'd42, 1, 0)));
        dir_rows.push_back(mk_row(MODE_TICK, 0, 0, 0, 0, 0, 1, bus_res(8'h00, 0, 0)));
        dir_rows.push_back(mk_row(MODE_TICK, 0, 0, 0, 0, 0, 1, bus_res(8'h00, 0, 0)));
        dir_rows.push_back(mk_row(MODE_TICK, 0, 0, 0, 0, 0, 1, bus_res(8'h00, 0, 0)));
        dir_rows.push_back(mk_row(MODE_TICK, 0, 0, 0, 0, 0, 1, bus_res(8'h00, 0, 0)));
        dir_rows.push_back(mk_row(MODE_TICK, 0, 0, 0, 0, 0, 1, bus_res(8'd43, 1, 0)));
        dir_rows.push_back(mk_row(MODE_TICK, 0, 0, 0, 0, 0, 1, bus_res(8'h00, 0, 0)));
        dir_rows.push_back(mk_row(MODE_TICK, 0, 0, 0, 0, 0, 1, bus_res(8'h00, 0, 0)));
        dir_rows.push_back(mk_row(MODE_TICK, 0, 0, 0, 0, 0, 1, bus_res(8'h00, 0, 0)));
        dir_rows.push_back(mk_row(MODE_TICK, 0, 0, 0, 0, 0, 1, bus_res(8'h00, 0, 0)));
        dir_rows.push_back(mk_row(MODE_TICK, 0, 0, 0, 0, 0, 1,
                                  bus_res(MEMORY_WRITE_CMD, 1, 0)));
        dir_rows.push_back(mk_row(MODE_TICK, 0, 0, 0, 0, 0, 1, bus_res(8'hA5, 0, 0)));
        dir_rows.push_back(mk_row(MODE_TICK, 0, 0, 0, 0, 0, 1, bus_res(8'hC3, 0, 1)));
        dir_rows.push_back(mk_row(MODE_TICK, -1, -1, -1, -1, 16'hFFFF, 1, idle_r));
        dir_rows.push_back(mk_row(MODE_REQUEST, 10, 10, 0, 5, 16'hFFFF, 1, idle_r));
        dir_rows.push_back(mk_row(MODE_REQUEST, 10, 10, 5, -32768, 16'hFFFF, 1, idle_r));
        dir_rows.push_back(mk_row(MODE_REQUEST, 240, 0, 5, 5, 16'h0F0F, 1, idle_r));
        dir_rows.push_back(mk_row(MODE_REQUEST, -32768, 0, 32767, 5, 16'h0F0F, 1, idle_r));
        dir_rows.push_back(mk_row(MODE_REQUEST, 32767, 32767, 32767, 32767, 0, 1, idle_r));
        dir_rows.push_back(mk_row(MODE_REQUEST, 0, -5, 5, 5, 16'h5555, 1, idle_r));
        // right and bottom edges far past the screen: clipped to one corner row
        dir_rows.push_back(mk_row(MODE_REQUEST, 230, 319, 32767, 32767, 16'h00FF, 1, acc_r));
        dir_rows.push_back(mk_row(MODE_TICK, 0, 0, 0, 0, 0, 0, idle_r));

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
        drain_fill();

        // random fills: mostly well-formed request plus ticks, with noise
        while (items_sent < RANDOM_ITEMS)
        begin
            if (episode % 7 == 0)
            begin
                wait_quiet();
                if (episode == 0)
                begin
                    write_reg(REG_COLUMN_SET_CMD, 8'h00);
                    write_reg(REG_PAGE_SET_CMD, 8'hFF);
                end
                else if (episode == 7)
                begin
                    write_reg(REG_PAGE_SET_CMD, 8'h00);
                    write_reg(REG_COLUMN_SET_CMD, 8'hFF);
                end
                else
                begin
                    write_reg(REG_COLUMN_SET_CMD, 8'($urandom));
                    write_reg(REG_PAGE_SET_CMD, 8'($urandom));
                end
            end
            no_gaps = ($urandom_range(0, 99) < 15);
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 3)) send_item(noise_item(MODE_TICK));
            if ($urandom_range(0, 3) == 0)
                send_item(fill_request(1'b0));
            send_item(fill_request(1'b1));
            // long receiver hold-off while ticks keep coming
            if (episode == 5)
                hold_req = 1'b1;
            drain_fill();
            episode++;
        end

        // full-screen fill: window extremes and a header plus some pixels
        no_gaps = 1'b1;
        big            = noise_item(MODE_REQUEST);
        big.rect_x     = -16'sd100;
        big.rect_y     = -16'sd1;
        big.rect_w     = 16'sd32767;
        big.rect_h     = 16'sd32767;
        send_item(big);
        repeat (PIXEL_STEP + 40) send_item(noise_item(MODE_TICK));

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_bus_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[files.f]
rtl/core/lrfbs_pkg.sv
rtl/core/lrfbs_clip.sv
rtl/core/lrfbs_engine.sv
rtl/core/lcd_rect_fill_bus_sequencer.sv
verif/tb_lcd_rect_fill_bus_sequencer.sv
